@@ hdl/ocv_pkg.sv @@
package ocv_pkg;

    localparam int BLOCK_LEN_DEF = 256;
    localparam int SAMPLE_W      = 16;
    localparam int TAIL_W        = 32;
    localparam int KLEN_W        = 9;
    localparam int TAP_IDX_W     = 8;
    localparam int FRAC_BITS     = 15;

    typedef struct packed {
        logic                       op;
        logic [TAP_IDX_W-1:0]       tap_index;
        logic signed [SAMPLE_W-1:0] value;
    } ocv_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       block_end;
    } ocv_out_t;

    typedef struct packed {
        logic clr;
        logic vld;
    } ocv_mac_ctrl_t;

    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

@@ hdl/ocv_ram.sv @@
module ocv_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/ocv_mac.sv @@
module ocv_mac #(
    parameter int BlockLen = ocv_pkg::BLOCK_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ocv_pkg::ocv_mac_ctrl_t               ctrl,
    input  logic signed [ocv_pkg::SAMPLE_W-1:0]  tap,
    input  logic signed [ocv_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [2*ocv_pkg::SAMPLE_W+$clog2(BlockLen)-ocv_pkg::FRAC_BITS-1:0] rounded
);
    import ocv_pkg::*;

    localparam int ProdW = 2 * SAMPLE_W;
    localparam int AccW  = ProdW + $clog2(BlockLen);
    localparam int RndW  = AccW - FRAC_BITS;

    logic signed [ProdW-1:0] prod_reg;
    logic                    pv_reg;
    logic signed [AccW-1:0]  acc_reg, acc_next;
    logic signed [AccW-1:0]  acc_biased;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + AccW'(prod_reg);
        end
    end

    // round half up: floor((acc + 2^14) / 2^15)
    assign acc_biased = acc_reg + AccW'(1 << (FRAC_BITS - 1));
    assign rounded    = RndW'(acc_biased >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg  <= ctrl.vld;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.vld)
        begin
            prod_reg <= tap * sample;
        end
    end

endmodule

@@ hdl/overlap_add_fft_convolver.sv @@
// Overlap-add block FIR filter. Taps (op 0) and samples (op 1) share the input
// channel; each sample returns one sample of the previously completed block,
// so output trails input by BlockLen samples. A tap write is taken in the idle
// state; a sample that does not complete a block passes through the output
// read back to idle. The sample that completes a block stalls the input while
// the block is convolved with one shared multiply-accumulate unit reading the
// tap and sample memories: each of the 2*BlockLen output terms goes through
// set-up, one issue per contributing tap (kernel_len capped at BlockLen),
// drain and tail write-back; the first BlockLen terms instead add the tail and
// write the output memory. After reset a clearing pass zeroes the tap, tail and
// output memories; configuration writes are taken only while idle.
module overlap_add_fft_convolver #(
    parameter int BlockLen = ocv_pkg::BLOCK_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ocv_pkg::ocv_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ocv_pkg::ocv_out_t           out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ocv_pkg::KLEN_W-1:0]  cfg_data
);
    import ocv_pkg::*;

    localparam int AW   = $clog2(BlockLen);
    localparam int CW   = $clog2(2 * BlockLen);
    localparam int RndW = 2 * SAMPLE_W + $clog2(BlockLen) - FRAC_BITS;
    localparam int SumW = TAIL_W + 1;
    localparam logic [CW-1:0] N_C      = CW'(BlockLen);
    localparam logic [CW-1:0] LAST_N_C = CW'(2 * BlockLen - 1);
    localparam logic [AW-1:0] LAST_A_C = AW'(BlockLen - 1);
    localparam logic signed [SumW-1:0] SAT_HI = SumW'(32767);
    localparam logic signed [SumW-1:0] SAT_LO = -SumW'(32768);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RD_OUT = 8'b0000_0100,
        ST_START  = 8'b0000_1000,
        ST_ISSUE  = 8'b0001_0000,
        ST_DRAIN  = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_FIN_WR = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [KLEN_W-1:0]     kernel_len_reg, kernel_len_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [1:0]            drain_reg, drain_next;
    logic                  rd_vld_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_reg, last_next;
    ocv_out_t              out_reg;

    logic                  accept, out_take, issue;
    logic [CW-1:0]         taps_c, kmin, hi_c, j_c;
    logic                  empty;

    logic                  k_we, x_we, t_we, o_we;
    logic [AW-1:0]         k_waddr, x_waddr, t_waddr, o_waddr;
    logic [SAMPLE_W-1:0]   k_wdata, o_wdata;
    logic [TAIL_W-1:0]     t_wdata;
    logic [AW-1:0]         k_raddr, x_raddr, t_raddr;
    logic [SAMPLE_W-1:0]   k_rdata, x_rdata, o_rdata;
    logic [TAIL_W-1:0]     t_rdata;

    ocv_mac_ctrl_t         mac_ctrl;
    logic signed [RndW-1:0] rounded;
    logic signed [SumW-1:0] head_sum;

    // kernel length is held while a block is being convolved
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign issue     = (state_reg == ST_ISSUE);

    assign taps_c = (int'(kernel_len_reg) > BlockLen) ? N_C : CW'(kernel_len_reg);
    assign kmin   = (n_reg >= N_C) ? (n_reg - N_C + CW'(1)) : '0;
    assign hi_c   = (n_reg < taps_c) ? n_reg : (taps_c - CW'(1));
    assign empty  = (taps_c == '0) || (kmin > hi_c);
    assign j_c    = n_reg - k_reg;

    assign head_sum = SumW'(rounded) + $signed({t_rdata[TAIL_W-1], t_rdata});

    assign mac_ctrl.clr = (state_reg == ST_START);
    assign mac_ctrl.vld = rd_vld_reg;

    always_comb
    begin
        state_next      = state_reg;
        kernel_len_next = kernel_len_reg;
        pos_next        = pos_reg;
        clr_next        = clr_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        hi_next         = hi_reg;
        drain_next      = drain_reg;
        out_valid_next  = out_valid_reg && !out_take;
        last_next       = last_reg;

        k_we = 1'b0; k_waddr = AW'(in_data.tap_index); k_wdata = in_data.value;
        x_we = 1'b0; x_waddr = pos_reg;
        t_we = 1'b0; t_waddr = n_reg[AW-1:0];          t_wdata = TAIL_W'(rounded);
        o_we = 1'b0; o_waddr = n_reg[AW-1:0];          o_wdata = '0;
        k_raddr = k_reg[AW-1:0];
        x_raddr = j_c[AW-1:0];
        t_raddr = n_reg[AW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            kernel_len_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                k_we = 1'b1; k_waddr = clr_reg; k_wdata = '0;
                t_we = 1'b1; t_waddr = clr_reg; t_wdata = '0;
                o_we = 1'b1; o_waddr = clr_reg; o_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == OP_TAP)
                    begin
                        k_we = (int'(in_data.tap_index) < BlockLen);
                    end
                    else
                    begin
                        x_we       = 1'b1;
                        last_next  = (pos_reg == LAST_A_C);
                        pos_next   = (pos_reg == LAST_A_C) ? '0 : pos_reg + AW'(1);
                        state_next = ST_RD_OUT;
                    end
                end
            end
            ST_RD_OUT:
            begin
                out_valid_next = 1'b1;
                n_next         = '0;
                state_next     = last_reg ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                k_next     = kmin;
                hi_next    = hi_c;
                drain_next = '0;
                state_next = empty ? ST_DRAIN : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                k_next = k_reg + CW'(1);
                if (k_reg == hi_reg)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // memory read, then product, then accumulate
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd1)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (n_reg < N_C)
                begin
                    state_next = ST_FIN_WR;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = AW'(n_reg - N_C);
                    n_next  = n_reg + CW'(1);
                    state_next = (n_reg == LAST_N_C) ? ST_IDLE : ST_START;
                end
            end
            ST_FIN_WR:
            begin
                o_we = 1'b1;
                if (head_sum > SAT_HI)
                begin
                    o_wdata = SAMPLE_W'(SAT_HI);
                end
                else if (head_sum < SAT_LO)
                begin
                    o_wdata = SAMPLE_W'(SAT_LO);
                end
                else
                begin
                    o_wdata = SAMPLE_W'(head_sum);
                end
                n_next     = n_reg + CW'(1);
                state_next = ST_START;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            kernel_len_reg <= '0;
            pos_reg        <= '0;
            clr_reg        <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            hi_reg         <= '0;
            drain_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kernel_len_reg <= kernel_len_next;
            pos_reg        <= pos_next;
            clr_reg        <= clr_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            hi_reg         <= hi_next;
            drain_reg      <= drain_next;
            rd_vld_reg     <= issue;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_OUT)
        begin
            out_reg.filtered  <= o_rdata;
            out_reg.block_end <= last_reg;
        end
    end

    ocv_ram #(.Width(SAMPLE_W), .Depth(BlockLen)) u_kernel_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    ocv_ram #(.Width(SAMPLE_W), .Depth(BlockLen)) u_input_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (in_data.value),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    ocv_ram #(.Width(TAIL_W), .Depth(BlockLen)) u_tail_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    ocv_ram #(.Width(SAMPLE_W), .Depth(BlockLen)) u_output_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (pos_reg),
        .rdata (o_rdata)
    );

    ocv_mac #(.BlockLen(BlockLen)) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .tap     ($signed(k_rdata)),
        .sample  ($signed(x_rdata)),
        .rounded (rounded)
    );

`ifndef SYNTHESIS
    a_sample_reads_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.op == OP_SAMPLE |=> state_reg == ST_RD_OUT)
        else $error("sample item not followed by output read");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RD_OUT))
        else $error("result raised outside output read");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> k_reg <= hi_reg && k_reg <= n_reg)
        else $error("tap index past convolution range");

    a_fill_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE || state_reg == ST_FIN |=> $stable(pos_reg))
        else $error("fill position moved during block processing");
`endif

endmodule

@@ bench/overlap_add_fft_convolver_tb.sv @@
module overlap_add_fft_convolver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocv_pkg::*;

    localparam int N = BLOCK_LEN_DEF;
    // worst block: N taps times N terms plus set-up, with margin
    localparam int BLOCK_CYCLES = N * N + 12 * N + 1000;

    class fir_scoreboard;
        int      taps[N];
        int      samples[N];
        int      tail[N];
        int      outblk[N];
        int      fill;
        int      klen;
        int      errors;
        int      checked;
        ocv_out_t expected_q[$];

        function new();
            foreach (taps[i])
            begin
                taps[i] = 0;
                samples[i] = 0;
                tail[i] = 0;
                outblk[i] = 0;
            end
            fill = 0;
            klen = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_len(int v);
            klen = v;
        endfunction

        function longint round_q15(longint v);
            return (v + 64'sd16384) >>> 15;
        endfunction

        function int sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function void convolve_block();
            longint acc[2*N];
            int     used;
            used = (klen > N) ? N : klen;
            foreach (acc[i]) acc[i] = 0;
            for (int k = 0; k < used; k++)
                for (int n = 0; n < N; n++)
                    acc[n + k] += longint'(taps[k]) * longint'(samples[n]);
            for (int n = 0; n < N; n++)
            begin
                outblk[n] = sat16(round_q15(acc[n]) + longint'(tail[n]));
                tail[n] = int'(round_q15(acc[n + N]));
            end
        endfunction

        function void note_input(ocv_in_t it);
            ocv_out_t e;
            if (it.op == OP_TAP)
            begin
                taps[it.tap_index] = int'(it.value);
                return;
            end
            e.filtered = 16'(outblk[fill]);
            e.block_end = (fill == N - 1);
            expected_q = {expected_q, e};
            samples[fill] = int'(it.value);
            fill++;
            if (fill == N)
            begin
                convolve_block();
                fill = 0;
            end
        endfunction

        function void check_result(ocv_out_t got);
            ocv_out_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item filtered=%0d block_end=%0b",
                         $time, got.filtered, got.block_end);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.filtered !== e.filtered)
            begin
                $display("%0t: filtered mismatch expected %0d actual %0d",
                         $time, e.filtered, got.filtered);
                errors++;
            end
            if (got.block_end !== e.block_end)
            begin
                $display("%0t: block_end mismatch expected %0b actual %0b",
                         $time, e.block_end, got.block_end);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    ocv_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    ocv_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [KLEN_W-1:0] cfg_data;

    fir_scoreboard sb = new();
    bit quiet;
    int n_taps;
    int n_samples;

    overlap_add_fft_convolver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: check what was taken at this edge, then pick next stall
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
            out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 27);
        end
    end

    task automatic send_item(ocv_in_t it);
        while (!quiet && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        if (it.op == OP_TAP) n_taps++;
        else n_samples++;
    endtask

    task automatic write_len(int v);
        cfg_valid <= 1'b1;
        cfg_data <= KLEN_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_len(v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic ocv_in_t make_item(logic op, int idx, int v);
        ocv_in_t it;
        it.op = op;
        it.tap_index = TAP_IDX_W'(idx);
        it.value = SAMPLE_W'(v);
        return it;
    endfunction

    function automatic ocv_in_t rand_item();
        ocv_in_t it;
        it.op = ($urandom_range(0, 99) < 15) ? OP_TAP : OP_SAMPLE;
        it.tap_index = TAP_IDX_W'($urandom_range(0, 255));
        // mostly modest taps so that outputs do not just saturate
        if (it.op == OP_TAP && $urandom_range(0, 99) < 80)
            it.value = SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
        else
            it.value = SAMPLE_W'($urandom);
        return it;
    endfunction

    initial
    begin
        int lens[5] = '{4, 256, 511, 0, 37};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        n_taps = 0;
        n_samples = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                // last block may still be convolving
                repeat (BLOCK_CYCLES) @(posedge clk);
            end
            quiet = (p == 3);
            write_len(lens[p]);
            if (p == 0)
            begin
                send_item(make_item(OP_TAP, 0, 32767));
                send_item(make_item(OP_TAP, 1, -32768));
                send_item(make_item(OP_TAP, 2, 1000));
                send_item(make_item(OP_TAP, 3, -1));
                send_item(make_item(OP_TAP, 255, -5));
                send_item(make_item(OP_SAMPLE, 0, 32767));
                send_item(make_item(OP_SAMPLE, 255, -32768));
                send_item(make_item(OP_SAMPLE, 170, 0));
                send_item(make_item(OP_SAMPLE, 85, -1));
                send_item(make_item(OP_SAMPLE, 0, 1));
                send_item(make_item(OP_TAP, 1, 0));
                send_item(make_item(OP_SAMPLE, 0, 32767));
            end
            repeat (188) send_item(rand_item());
        end
        drain();
        repeat (BLOCK_CYCLES) @(posedge clk);

        $display("Ran %0d tap writes and %0d samples over five kernel lengths,",
                 n_taps, n_samples);
        $display("%0d filtered items checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Timeout with %0d items outstanding", sb.expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ocv_pkg.sv
hdl/ocv_ram.sv
hdl/ocv_mac.sv
hdl/overlap_add_fft_convolver.sv
bench/overlap_add_fft_convolver_tb.sv
